FILE: design/ubt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ubt_pkg: shared types, constants and microprogram
// Register indexes, reset values, control word layout and the trim scan
// program that the sequencer steps through.
// ----------------------------------------------------------------------------
package ubt_pkg;

  localparam int unsigned DEF_MAX_WIDTH  = 256;
  localparam int unsigned DEF_MAX_HEIGHT = 256;

  localparam int unsigned CFG_W       = 9;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned PIXEL_W     = 32;
  localparam int unsigned COORD_OUT_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_KEPT     = 2'd2;

  localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 9'd256;
  localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 9'd256;
  localparam logic [CFG_W-1:0] RST_MIN_KEPT     = 9'd8;

  localparam int unsigned STEP_W = 4;
  typedef logic [STEP_W-1:0] ubt_step_t;

  // Program addresses
  localparam ubt_step_t S_IDLE     = 4'd0;
  localparam ubt_step_t S_INIT     = 4'd1;
  localparam ubt_step_t S_TEST     = 4'd2;
  localparam ubt_step_t S_REF_RD   = 4'd3;
  localparam ubt_step_t S_REF_LAT  = 4'd4;
  localparam ubt_step_t S_ELEM_RD  = 4'd5;
  localparam ubt_step_t S_ELEM_CHK = 4'd6;
  localparam ubt_step_t S_PASS_END = 4'd7;
  localparam ubt_step_t S_PASS_ADV = 4'd8;
  localparam ubt_step_t S_SHRINK   = 4'd9;
  localparam ubt_step_t S_OUT_WAIT = 4'd10;
  localparam ubt_step_t S_FINISH   = 4'd11;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_INIT,
    OP_RD_REF,
    OP_LATCH_REF,
    OP_RD_ELEM,
    OP_SHRINK,
    OP_ADV_PASS,
    OP_FINISH
  } ubt_op_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_START,
    C_BAND_EMPTY,
    C_IDX_PAST,
    C_MATCH,
    C_LAST_PASS,
    C_OUT_BUSY
  } ubt_cond_e;

  typedef struct packed {
    ubt_op_e   op;
    ubt_cond_e cond;
    ubt_step_t target;
  } ubt_uword_t;

  typedef struct packed {
    logic band_empty;
    logic idx_past;
    logic match;
    logic last_pass;
  } ubt_stat_t;

  typedef struct packed {
    logic [COORD_OUT_W-1:0] left_col;
    logic [COORD_OUT_W-1:0] top_row;
    logic [COORD_OUT_W-1:0] right_col;
    logic [COORD_OUT_W-1:0] bottom_row;
    logic                   fell_back;
  } ubt_res_t;

  // Trim scan program: jump to target when the condition holds, else step on.
  function automatic ubt_uword_t ubt_ucode(input ubt_step_t step);
    ubt_uword_t w;
    w = '{op: OP_NOP, cond: C_ALWAYS, target: S_IDLE};
    case (step)
      S_IDLE:     w = '{op: OP_NOP,       cond: C_NO_START,   target: S_IDLE};
      S_INIT:     w = '{op: OP_INIT,      cond: C_NEVER,      target: S_IDLE};
      S_TEST:     w = '{op: OP_NOP,       cond: C_BAND_EMPTY, target: S_PASS_END};
      S_REF_RD:   w = '{op: OP_RD_REF,    cond: C_NEVER,      target: S_IDLE};
      S_REF_LAT:  w = '{op: OP_LATCH_REF, cond: C_NEVER,      target: S_IDLE};
      S_ELEM_RD:  w = '{op: OP_RD_ELEM,   cond: C_IDX_PAST,   target: S_SHRINK};
      S_ELEM_CHK: w = '{op: OP_NOP,       cond: C_MATCH,      target: S_ELEM_RD};
      S_PASS_END: w = '{op: OP_NOP,       cond: C_LAST_PASS,  target: S_OUT_WAIT};
      S_PASS_ADV: w = '{op: OP_ADV_PASS,  cond: C_ALWAYS,     target: S_TEST};
      S_SHRINK:   w = '{op: OP_SHRINK,    cond: C_ALWAYS,     target: S_TEST};
      S_OUT_WAIT: w = '{op: OP_NOP,       cond: C_OUT_BUSY,   target: S_OUT_WAIT};
      S_FINISH:   w = '{op: OP_FINISH,    cond: C_ALWAYS,     target: S_IDLE};
      default:    w = '{op: OP_NOP,       cond: C_ALWAYS,     target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

FILE: design/ubt_fstore.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ubt_fstore: frame store
// One write port for loading, one registered read port for the scan.
// ----------------------------------------------------------------------------
module ubt_fstore #(
  parameter int unsigned AW = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        wr_en_i,
  input  wire logic [AW-1:0]               wr_addr_i,
  input  wire logic [ubt_pkg::PIXEL_W-1:0] wr_data_i,
  input  wire logic                        rd_en_i,
  input  wire logic [AW-1:0]               rd_addr_i,
  output logic      [ubt_pkg::PIXEL_W-1:0] rd_data_o
);
  import ubt_pkg::*;

  localparam int unsigned DEPTH = 1 << AW;

  logic [PIXEL_W-1:0] mem_q [DEPTH];
  logic [PIXEL_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

FILE: design/ubt_useq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ubt_useq: microprogram sequencer
// Step counter over the program ROM with one conditional jump per step.
// ----------------------------------------------------------------------------
module ubt_useq (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic                out_busy_i,
  input  wire ubt_pkg::ubt_stat_t  stat_i,
  output ubt_pkg::ubt_uword_t      uword_o,
  output logic                     busy_o
);
  import ubt_pkg::*;

  ubt_step_t  step_q, step_d;
  ubt_uword_t uw;
  logic       take;

  assign uw = ubt_ucode(step_q);

  always_comb begin
    case (uw.cond)
      C_NEVER:      take = 1'b0;
      C_ALWAYS:     take = 1'b1;
      C_NO_START:   take = !start_i;
      C_BAND_EMPTY: take = stat_i.band_empty;
      C_IDX_PAST:   take = stat_i.idx_past;
      C_MATCH:      take = stat_i.match;
      C_LAST_PASS:  take = stat_i.last_pass;
      C_OUT_BUSY:   take = out_busy_i;
      default:      take = 1'b1;
    endcase
    step_d = take ? uw.target : step_q + 4'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= S_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  assign uword_o = uw;
  assign busy_o  = (step_q != S_IDLE);

  // The counter never leaves the program.
  a_step_in_program: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= S_FINISH)
    else $error("sequencer stepped outside the program");

endmodule
`default_nettype wire

FILE: design/ubt_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ubt_dpath: trim datapath
// Bounds, band index and reference pixel, steered by the control word.
// ----------------------------------------------------------------------------
module ubt_dpath #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  localparam int unsigned XW = $clog2(MAX_WIDTH + 1),
  localparam int unsigned YW = $clog2(MAX_HEIGHT + 1),
  localparam int unsigned IW = (XW > YW) ? XW : YW,
  localparam int unsigned CW = $clog2(MAX_WIDTH),
  localparam int unsigned RW = $clog2(MAX_HEIGHT),
  localparam int unsigned AW = CW + RW
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire ubt_pkg::ubt_uword_t         uword_i,
  input  wire logic [IW-1:0]               w_eff_i,
  input  wire logic [IW-1:0]               h_eff_i,
  input  wire logic [ubt_pkg::CFG_W-1:0]   min_kept_i,
  input  wire logic [ubt_pkg::PIXEL_W-1:0] rd_data_i,
  output logic                             rd_en_o,
  output logic      [AW-1:0]               rd_addr_o,
  output ubt_pkg::ubt_stat_t               stat_o,
  output ubt_pkg::ubt_res_t                res_o
);
  import ubt_pkg::*;

  localparam int unsigned KW = ((IW > CFG_W) ? IW : CFG_W) + 1;

  typedef enum logic [1:0] {PASS_TOP, PASS_BOTTOM, PASS_LEFT, PASS_RIGHT} pass_e;

  logic [IW-1:0]      lo_q, lo_d, tp_q, tp_d, rt_q, rt_d, bt_q, bt_d;
  logic [IW-1:0]      idx_q, idx_d;
  logic [PIXEL_W-1:0] ref_q, ref_d;
  pass_e              pass_q, pass_d;

  logic [IW-1:0] fix, first, stop, idx_sel;
  logic          row_mode, empty;
  logic [KW-1:0] kept_w, kept_h;
  logic          fb;

  // Band geometry of the current pass
  always_comb begin
    case (pass_q)
      PASS_TOP: begin
        fix = tp_q; first = lo_q; stop = rt_q; row_mode = 1'b1; empty = (tp_q >= bt_q);
      end
      PASS_BOTTOM: begin
        fix = bt_q; first = lo_q; stop = rt_q; row_mode = 1'b1; empty = (tp_q >= bt_q);
      end
      PASS_LEFT: begin
        fix = lo_q; first = tp_q; stop = bt_q; row_mode = 1'b0; empty = (lo_q >= rt_q);
      end
      default: begin
        fix = rt_q; first = tp_q; stop = bt_q; row_mode = 1'b0; empty = (lo_q >= rt_q);
      end
    endcase
  end

  assign idx_sel   = (uword_i.op == OP_RD_REF) ? first : idx_q;
  assign rd_en_o   = (uword_i.op == OP_RD_REF) || (uword_i.op == OP_RD_ELEM);
  assign rd_addr_o = row_mode ? {fix[RW-1:0], idx_sel[CW-1:0]}
                              : {idx_sel[RW-1:0], fix[CW-1:0]};

  always_comb begin
    lo_d   = lo_q;
    tp_d   = tp_q;
    rt_d   = rt_q;
    bt_d   = bt_q;
    idx_d  = idx_q;
    ref_d  = ref_q;
    pass_d = pass_q;
    case (uword_i.op)
      OP_INIT: begin
        lo_d   = '0;
        tp_d   = '0;
        rt_d   = w_eff_i - IW'(1);
        bt_d   = h_eff_i - IW'(1);
        pass_d = PASS_TOP;
      end
      OP_RD_REF:    idx_d = first + IW'(1);
      OP_LATCH_REF: ref_d = rd_data_i;
      OP_RD_ELEM:   idx_d = idx_q + IW'(1);
      OP_SHRINK: begin
        case (pass_q)
          PASS_TOP:    tp_d = tp_q + IW'(1);
          PASS_BOTTOM: bt_d = bt_q - IW'(1);
          PASS_LEFT:   lo_d = lo_q + IW'(1);
          default:     rt_d = rt_q - IW'(1);
        endcase
      end
      OP_ADV_PASS:  pass_d = pass_e'(pass_q + 2'd1);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q   <= '0;
      tp_q   <= '0;
      rt_q   <= '0;
      bt_q   <= '0;
      pass_q <= PASS_TOP;
    end else begin
      lo_q   <= lo_d;
      tp_q   <= tp_d;
      rt_q   <= rt_d;
      bt_q   <= bt_d;
      pass_q <= pass_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    ref_q <= ref_d;
  end

  assign stat_o.band_empty = empty;
  assign stat_o.idx_past   = (idx_q > stop);
  assign stat_o.match      = (rd_data_i == ref_q);
  assign stat_o.last_pass  = (pass_q == PASS_RIGHT);

  // Kept size check; a zero minimum never trips it
  assign kept_w = KW'(rt_q) - KW'(lo_q) + KW'(1);
  assign kept_h = KW'(bt_q) - KW'(tp_q) + KW'(1);
  assign fb     = (kept_w < KW'(min_kept_i)) || (kept_h < KW'(min_kept_i));

  assign res_o.left_col   = fb ? '0 : COORD_OUT_W'(lo_q);
  assign res_o.top_row    = fb ? '0 : COORD_OUT_W'(tp_q);
  assign res_o.right_col  = fb ? COORD_OUT_W'(w_eff_i - IW'(1)) : COORD_OUT_W'(rt_q);
  assign res_o.bottom_row = fb ? COORD_OUT_W'(h_eff_i - IW'(1)) : COORD_OUT_W'(bt_q);
  assign res_o.fell_back  = fb;

endmodule
`default_nettype wire

FILE: design/uniform_border_trim_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uniform_border_trim_unit: trim uniform border bands from a stored frame
// Loads one frame in raster order, then reports the bounds left after
// cutting top, bottom, left and right bands that are all one color.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one 32-bit pixel per request (in_valid_i / in_stall_o).
//   Pixels load at one per cycle while in_stall_o is low; the frame size
//   comes from the frame_width and frame_height registers. Writing either one
//   restarts loading. After the last pixel of a frame, in_stall_o rises while
//   the scan runs. The scan begins with a setup step; for each band tested it
//   reads the band's first pixel and compares each further pixel against it,
//   cutting the band when all match. Each of the four passes closes when its
//   band holds a differing pixel or is empty, and the result is written once
//   the output register is free. Every compare is one read of the single
//   read port of the frame store and one compare step of the microprogram.
//   Output channel: one request per frame (out_valid_o / out_stall_i) with
//   the four bounds and the fall-back flag. A result waits in the output
//   register; loading of the next frame goes on meanwhile, and a finished
//   scan holds until the register is free.
//   Reset: registers return to 256 x 256 with minimum 8, loading restarts at
//   pixel 0, no result pending. The store needs no clearing pass.
//   Configuration writes are accepted every cycle (cfg_ready_o tied high).
// ----------------------------------------------------------------------------
module uniform_border_trim_unit #(
  parameter int unsigned MAX_WIDTH  = ubt_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = ubt_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [ubt_pkg::PIXEL_W-1:0]     pixel_word_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic      [ubt_pkg::COORD_OUT_W-1:0] left_col_o,
  output logic      [ubt_pkg::COORD_OUT_W-1:0] top_row_o,
  output logic      [ubt_pkg::COORD_OUT_W-1:0] right_col_o,
  output logic      [ubt_pkg::COORD_OUT_W-1:0] bottom_row_o,
  output logic                                 fell_back_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [ubt_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [ubt_pkg::CFG_W-1:0]       cfg_data_i
);
  import ubt_pkg::*;

  localparam int unsigned XW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned YW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned IW = (XW > YW) ? XW : YW;
  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);
  localparam int unsigned AW = CW + RW;

  // Configuration registers
  logic [CFG_W-1:0] width_q, height_q, min_kept_q;
  logic             cfg_we;

  // Load position
  logic [IW-1:0] col_q, col_d, row_q, row_d;
  logic [IW-1:0] w_eff, h_eff;
  logic          in_acc, last_col, last_row, frame_done;

  // Sequencer and datapath
  ubt_uword_t         uword;
  ubt_stat_t          stat;
  ubt_res_t           res;
  logic               seq_busy;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [PIXEL_W-1:0] rd_data;

  // Output register
  logic     out_valid_q;
  ubt_res_t res_q;
  logic     out_busy;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= RST_FRAME_WIDTH;
      height_q   <= RST_FRAME_HEIGHT;
      min_kept_q <= RST_MIN_KEPT;
    end else if (cfg_we) begin
      case (cfg_index_i)
        REG_FRAME_WIDTH:  width_q    <= cfg_data_i;
        REG_FRAME_HEIGHT: height_q   <= cfg_data_i;
        REG_MIN_KEPT:     min_kept_q <= cfg_data_i;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Saturate the frame size into 1..MAX
  always_comb begin
    if (width_q == '0) begin
      w_eff = IW'(1);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      w_eff = IW'(MAX_WIDTH);
    end else begin
      w_eff = IW'(width_q);
    end
    if (height_q == '0) begin
      h_eff = IW'(1);
    end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
      h_eff = IW'(MAX_HEIGHT);
    end else begin
      h_eff = IW'(height_q);
    end
  end

  // Hold the input off for the whole scan
  assign in_stall_o = seq_busy;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign last_col   = (col_q == w_eff - IW'(1));
  assign last_row   = (row_q == h_eff - IW'(1));
  assign frame_done = in_acc && last_col && last_row;

  // Advance the raster position; a size write restarts the frame
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_we && (cfg_index_i == REG_FRAME_WIDTH || cfg_index_i == REG_FRAME_HEIGHT)) begin
      col_d = '0;
      row_d = '0;
    end else if (in_acc) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + IW'(1);
      end else begin
        col_d = col_q + IW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  ubt_fstore #(
    .AW (AW)
  ) u_fstore (
    .clk_i     (clk_i),
    .wr_en_i   (in_acc),
    .wr_addr_i ({row_q[RW-1:0], col_q[CW-1:0]}),
    .wr_data_i (pixel_word_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  ubt_useq u_useq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (frame_done),
    .out_busy_i (out_busy),
    .stat_i     (stat),
    .uword_o    (uword),
    .busy_o     (seq_busy)
  );

  ubt_dpath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .uword_i    (uword),
    .w_eff_i    (w_eff),
    .h_eff_i    (h_eff),
    .min_kept_i (min_kept_q),
    .rd_data_i  (rd_data),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .stat_o     (stat),
    .res_o      (res)
  );

  // The register is free once its request is taken in this cycle
  assign out_busy = out_valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (uword.op == OP_FINISH) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (uword.op == OP_FINISH) begin
      res_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign left_col_o   = res_q.left_col;
  assign top_row_o    = res_q.top_row;
  assign right_col_o  = res_q.right_col;
  assign bottom_row_o = res_q.bottom_row;
  assign fell_back_o  = res_q.fell_back;

  // A result appears only right after the finishing step of the program.
  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(uword.op == OP_FINISH))
    else $error("result raised without a finished scan");

  // Fall-back results carry the frame origin.
  a_fallback_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && fell_back_o) |-> (left_col_o == '0 && top_row_o == '0))
    else $error("fall-back result not anchored at the origin");

  // Loading restarts at the frame origin while the scan runs.
  a_load_parked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_busy |-> (col_q == '0 && row_q == '0))
    else $error("load position moved during the scan");

  // The raster position stays inside the frame.
  a_load_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_q < w_eff) && (row_q < h_eff))
    else $error("load position outside the frame");

endmodule
`default_nettype wire
